[rtl/sha1_byte_stream_hasher_macros.svh]
// assertion macros for the sha-1 byte stream hasher
`ifndef SHA1_BYTE_STREAM_HASHER_MACROS_SVH
`define SHA1_BYTE_STREAM_HASHER_MACROS_SVH
`ifndef SYNTHESIS
`define SHA1_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sha1 hasher check failed");
`define SHA1_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sha1 hasher check failed");
`else
`define SHA1_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SHA1_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/sha1_bsh_pkg.sv]
// types and constants for the sha-1 byte stream hasher
package sha1_bsh_pkg;

  localparam int unsigned NUM_WORDS  = 5;
  localparam int unsigned WIN_DEPTH  = 16;
  localparam int unsigned ROUNDS     = 80;
  localparam int unsigned ROUND_W    = $clog2(ROUNDS);
  localparam int unsigned IDX_W      = $clog2(NUM_WORDS);

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [5:0] LAST_POS    = 6'd63;
  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
  localparam logic [IDX_W-1:0]   LAST_IDX   = IDX_W'(NUM_WORDS - 1);
  localparam logic [ROUND_W-1:0] ROUND_ONE  = ROUND_W'(1);
  localparam logic [IDX_W-1:0]   IDX_ONE    = IDX_W'(1);

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  typedef logic [31:0] chain_t [NUM_WORDS];
  typedef logic [31:0] window_t [WIN_DEPTH];

  localparam chain_t IV = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                            32'h10325476, 32'hC3D2E1F0};

  typedef enum logic [1:0] {
    FN_ADD     = 2'd0,
    FN_ADD_FIN = 2'd1,
    FN_FIN     = 2'd2,
    FN_NONE    = 2'd3
  } func_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_PAD   = 5'b00010,
    ST_ROUND = 5'b00100,
    ST_ADD   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_t;

endpackage

[rtl/sha1_byte_stream_hasher.sv]
// sha-1 hasher taking one message byte per transfer, one round per cycle
//
//  channel  dir  handshake                 payload
//  in_      in   in_valid / in_ready       in_data_byte[7:0], in_func[1:0]
//  out_     out  out_valid / out_ready     out_digest_word[31:0], out_word_index[2:0],
//                                          out_last_word
//
// a plain byte is only written into the window; the byte that fills a block starts
// compression (80 rounds on the shared round adder, then one chaining add)
// a finish pads one byte a cycle up to the block end, then compresses; when
// the marker lands at offset 56 or later a second, fully padded block follows
// the five digest words then leave one per transfer, held while out_ready is low
// in_ready is high only when no message work is in flight
// synchronous active-low reset loads the initial vector and clears the byte count
`include "sha1_byte_stream_hasher_macros.svh"

module sha1_byte_stream_hasher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic [1:0]  in_func,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sha1_bsh_pkg::state_t state_r, state_nxt;
  sha1_bsh_pkg::chain_t h_r, h_nxt;
  sha1_bsh_pkg::window_t w_r, w_nxt;

  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [60:0] byte_total_r, byte_total_nxt;
  logic [sha1_bsh_pkg::ROUND_W-1:0] round_r, round_nxt;
  logic [5:0] pad_pos_r, pad_pos_nxt;
  logic       mark_r, mark_nxt;
  logic       extra_r, extra_nxt;
  logic       fin_r, fin_nxt;
  logic       last_blk_r, last_blk_nxt;
  logic [sha1_bsh_pkg::IDX_W-1:0] out_idx_r, out_idx_nxt;

  logic [5:0]  pos;
  logic [5:0]  pos_inc;
  logic [63:0] bit_len;
  logic        in_xfer;
  logic        out_xfer;

  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] round_sum;
  logic [31:0] sched_mix;
  logic [31:0] sched_new;

  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_val;
  logic [7:0]  pad_val;

  assign pos      = byte_total_r[5:0];
  assign pos_inc  = pos + 6'd1;
  assign bit_len  = {byte_total_r, 3'b000};
  assign in_ready = (state_r == sha1_bsh_pkg::ST_IDLE);
  assign in_xfer  = in_valid && in_ready;

  assign out_valid       = (state_r == sha1_bsh_pkg::ST_OUT);
  assign out_xfer        = out_valid && out_ready;
  assign out_digest_word = h_r[out_idx_r];
  assign out_word_index  = out_idx_r;
  assign out_last_word   = (out_idx_r == sha1_bsh_pkg::LAST_IDX);

  // round function and constant by round group
  always_comb begin
    if (round_r inside {[0:19]}) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = sha1_bsh_pkg::K0;
    end else if (round_r inside {[20:39]}) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1_bsh_pkg::K1;
    end else if (round_r inside {[40:59]}) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = sha1_bsh_pkg::K2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = sha1_bsh_pkg::K3;
    end
  end

  assign round_sum = {a_r[26:0], a_r[31:27]} + f_val + e_r + k_val + w_r[0];
  assign sched_mix = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign sched_new = {sched_mix[30:0], sched_mix[31]};

  // padding byte: marker first, then zeros, length in the tail of the final block
  always_comb begin
    if (!mark_r) begin
      pad_val = sha1_bsh_pkg::PAD_BYTE;
    end else if (!extra_r && (pad_pos_r >= sha1_bsh_pkg::LEN_POS)) begin
      pad_val = bit_len[{~pad_pos_r[2:0], 3'b000} +: 8];
    end else begin
      pad_val = 8'h00;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    h_nxt          = h_r;
    w_nxt          = w_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    c_nxt          = c_r;
    d_nxt          = d_r;
    e_nxt          = e_r;
    byte_total_nxt = byte_total_r;
    round_nxt      = round_r;
    pad_pos_nxt    = pad_pos_r;
    mark_nxt       = mark_r;
    extra_nxt      = extra_r;
    fin_nxt        = fin_r;
    last_blk_nxt   = last_blk_r;
    out_idx_nxt    = out_idx_r;
    wr_en          = 1'b0;
    wr_pos         = pos;
    wr_val         = in_data_byte;

    case (state_r)
      sha1_bsh_pkg::ST_IDLE: begin
        if (in_xfer) begin
          case (sha1_bsh_pkg::func_t'(in_func))
            sha1_bsh_pkg::FN_ADD, sha1_bsh_pkg::FN_ADD_FIN: begin
              wr_en          = 1'b1;
              byte_total_nxt = byte_total_r + 61'd1;
              if (sha1_bsh_pkg::func_t'(in_func) == sha1_bsh_pkg::FN_ADD_FIN) begin
                fin_nxt      = 1'b1;
                mark_nxt     = 1'b0;
                last_blk_nxt = 1'b0;
                pad_pos_nxt  = pos_inc;
                extra_nxt    = (pos_inc >= sha1_bsh_pkg::LEN_POS);
                state_nxt    = sha1_bsh_pkg::ST_PAD;
              end
              // full block goes to compression first, padding resumes after
              if (pos == sha1_bsh_pkg::LAST_POS) begin
                state_nxt = sha1_bsh_pkg::ST_ROUND;
                round_nxt = '0;
                a_nxt     = h_r[0];
                b_nxt     = h_r[1];
                c_nxt     = h_r[2];
                d_nxt     = h_r[3];
                e_nxt     = h_r[4];
              end
            end
            sha1_bsh_pkg::FN_FIN: begin
              fin_nxt      = 1'b1;
              mark_nxt     = 1'b0;
              last_blk_nxt = 1'b0;
              pad_pos_nxt  = pos;
              extra_nxt    = (pos >= sha1_bsh_pkg::LEN_POS);
              state_nxt    = sha1_bsh_pkg::ST_PAD;
            end
            default: begin
            end
          endcase
        end
      end

      sha1_bsh_pkg::ST_PAD: begin
        wr_en       = 1'b1;
        wr_pos      = pad_pos_r;
        wr_val      = pad_val;
        mark_nxt    = 1'b1;
        pad_pos_nxt = pad_pos_r + 6'd1;
        if (pad_pos_r == sha1_bsh_pkg::LAST_POS) begin
          last_blk_nxt = !extra_r;
          state_nxt    = sha1_bsh_pkg::ST_ROUND;
          round_nxt    = '0;
          a_nxt        = h_r[0];
          b_nxt        = h_r[1];
          c_nxt        = h_r[2];
          d_nxt        = h_r[3];
          e_nxt        = h_r[4];
        end
      end

      sha1_bsh_pkg::ST_ROUND: begin
        a_nxt = round_sum;
        b_nxt = a_r;
        c_nxt = {b_r[1:0], b_r[31:2]};
        d_nxt = c_r;
        e_nxt = d_r;
        for (int i = 0; i < sha1_bsh_pkg::WIN_DEPTH - 1; i++) begin
          w_nxt[i] = w_r[i+1];
        end
        w_nxt[sha1_bsh_pkg::WIN_DEPTH-1] = sched_new;
        round_nxt = round_r + sha1_bsh_pkg::ROUND_ONE;
        if (round_r == sha1_bsh_pkg::LAST_ROUND) begin
          state_nxt = sha1_bsh_pkg::ST_ADD;
        end
      end

      sha1_bsh_pkg::ST_ADD: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        h_nxt[4] = h_r[4] + e_r;
        if (last_blk_r) begin
          state_nxt   = sha1_bsh_pkg::ST_OUT;
          out_idx_nxt = '0;
        end else if (fin_r) begin
          state_nxt = sha1_bsh_pkg::ST_PAD;
          extra_nxt = 1'b0;
        end else begin
          state_nxt = sha1_bsh_pkg::ST_IDLE;
        end
      end

      sha1_bsh_pkg::ST_OUT: begin
        if (out_xfer) begin
          if (out_idx_r == sha1_bsh_pkg::LAST_IDX) begin
            h_nxt          = sha1_bsh_pkg::IV;
            byte_total_nxt = '0;
            fin_nxt        = 1'b0;
            last_blk_nxt   = 1'b0;
            state_nxt      = sha1_bsh_pkg::ST_IDLE;
          end else begin
            out_idx_nxt = out_idx_r + sha1_bsh_pkg::IDX_ONE;
          end
        end
      end

      default: begin
        state_nxt = sha1_bsh_pkg::ST_IDLE;
      end
    endcase

    // big-endian byte lanes within each window word
    if (wr_en) begin
      w_nxt[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] = wr_val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= sha1_bsh_pkg::ST_IDLE;
      h_r          <= sha1_bsh_pkg::IV;
      byte_total_r <= '0;
      round_r      <= '0;
      pad_pos_r    <= '0;
      mark_r       <= 1'b0;
      extra_r      <= 1'b0;
      fin_r        <= 1'b0;
      last_blk_r   <= 1'b0;
      out_idx_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      h_r          <= h_nxt;
      byte_total_r <= byte_total_nxt;
      round_r      <= round_nxt;
      pad_pos_r    <= pad_pos_nxt;
      mark_r       <= mark_nxt;
      extra_r      <= extra_nxt;
      fin_r        <= fin_nxt;
      last_blk_r   <= last_blk_nxt;
      out_idx_r    <= out_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r <= w_nxt;
    a_r <= a_nxt;
    b_r <= b_nxt;
    c_r <= c_nxt;
    d_r <= d_nxt;
    e_r <= e_nxt;
  end

  `SHA1_ASSERT_IMP(a_no_overlap, clk, rst_n, in_ready, !out_valid)
  `SHA1_ASSERT_IMP(a_round_range, clk, rst_n, state_r == sha1_bsh_pkg::ST_ROUND,
    round_r <= sha1_bsh_pkg::LAST_ROUND)
  `SHA1_ASSERT_NXT(a_clean_restart, clk, rst_n, out_xfer && out_last_word,
    in_ready && (byte_total_r == '0) && (h_r[0] == sha1_bsh_pkg::IV[0]))
  `SHA1_ASSERT_NXT(a_pad_leads_round, clk, rst_n,
    (state_r == sha1_bsh_pkg::ST_PAD) && (pad_pos_r == sha1_bsh_pkg::LAST_POS),
    (state_r == sha1_bsh_pkg::ST_ROUND) && (round_r == '0))

endmodule
